// ----- rtl/dcfb_pkg.sv -----
// Shared types and constants for the dash CAN frame button decoder.
// No dependencies; every other file refers to this package by scoped names.
package dcfb_pkg;

    localparam int unsigned FRAME_BYTES = 17;
    localparam int unsigned CNT_W       = 5;
    localparam int unsigned ID_W        = 29;
    localparam int unsigned MAX_BUTTONS = 8;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned HOLD_W      = 16;

    localparam logic [7:0] LEAD_BYTE = 8'h44;
    localparam logic [7:0] SIG_1     = 8'h33;
    localparam logic [7:0] SIG_2     = 8'h22;
    localparam logic [7:0] SIG_3     = 8'h11;

    // Frame positions of the signature and the ID bytes
    localparam logic [CNT_W-1:0] POS_SIG_1 = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_SIG_2 = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_SIG_3 = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_ID_0  = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_ID_1  = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_ID_2  = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_ID_3  = CNT_W'(7);
    localparam logic [CNT_W-1:0] POS_LAST  = CNT_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_FRAME = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind        kind;
        logic [ID_W-1:0] id;
    } t_op;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ms;
        logic [7:0]        toggle_mask;
        logic [ID_W-1:0]   button_base_id;
        logic [ID_W-1:0]   screen_next_id;
    } t_cfg;

    // Packed so that switch_state lands in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0]    frame_id;
        logic               frame_done;
        logic signed [1:0]  screen_step;
        logic [7:0]         switch_state;
    } t_result;

endpackage

// ----- rtl/dash_can_frame_button_decoder.sv -----
// Top level of the dash CAN frame button decoder.
// Depends on dcfb_pkg, dcfb_front, dcfb_queue and dcfb_back.

// Receives a stream of serial bytes and millisecond ticks (tuser = 1 marks a
// tick) and returns exactly one result item per input item. Bytes are gathered
// into 17-byte frames that open with 0x44 and carry the signature 33 22 11 and
// a little-endian ID; the low 29 bits of a well-signed frame's ID request a
// screen step or set, toggle or clear one of the virtual buttons. Ticks
// advance a 32-bit millisecond count and release momentary buttons held
// longer than hold_ms. The front end tracks frame position and classifies each
// item; a two-entry queue hands the operations to the back end, which updates
// the button state and loads the output register. The block takes one item per
// clock cycle while the output is not stalled; each result is registered in the
// output register of the back end, and a stalled output fills the queue before the
// input side stops. Registers (APB, 32-bit, byte address 4*i): 0 hold_ms,
// 1 toggle_mask, 2 button_base_id, 3 screen_next_id; write them only while no
// item is in flight.
module dash_can_frame_button_decoder #(
    parameter int unsigned BUTTON_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] command (1 = millisecond tick)
    // result item stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] switch_state, [9:8] screen_step,
                                        // [10] frame_done, [39:11] frame_id
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_HOLD_MS     = 2'd0;
    localparam logic [1:0] REG_TOGGLE_MASK = 2'd1;
    localparam logic [1:0] REG_BUTTON_BASE = 2'd2;
    localparam logic [1:0] REG_SCREEN_NEXT = 2'd3;

    dcfb_pkg::t_cfg    r_cfg;
    dcfb_pkg::t_op     front_op;
    dcfb_pkg::t_op     queue_op;
    dcfb_pkg::t_result result;
    logic              in_accept;
    logic              queue_full;
    logic              queue_valid;
    logic              queue_pop;
    logic              cfg_write;

    // Accept whenever the queue has room
    assign s_axis_tready = !queue_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Register file: writes land on the access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ms        <= dcfb_pkg::HOLD_W'(200);
            r_cfg.toggle_mask    <= 8'd12;
            r_cfg.button_base_id <= dcfb_pkg::ID_W'(32'h500);
            r_cfg.screen_next_id <= dcfb_pkg::ID_W'(32'h800);
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_HOLD_MS:     r_cfg.hold_ms        <= pwdata[dcfb_pkg::HOLD_W-1:0];
                REG_TOGGLE_MASK: r_cfg.toggle_mask    <= pwdata[7:0];
                REG_BUTTON_BASE: r_cfg.button_base_id <= pwdata[dcfb_pkg::ID_W-1:0];
                REG_SCREEN_NEXT: r_cfg.screen_next_id <= pwdata[dcfb_pkg::ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HOLD_MS:     prdata = 32'(r_cfg.hold_ms);
            REG_TOGGLE_MASK: prdata = 32'(r_cfg.toggle_mask);
            REG_BUTTON_BASE: prdata = 32'(r_cfg.button_base_id);
            REG_SCREEN_NEXT: prdata = 32'(r_cfg.screen_next_id);
            default:         prdata = '0;
        endcase
    end

    // Classify each accepted item
    dcfb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_command (s_axis_tuser),
        .i_rx_byte (s_axis_tdata),
        .o_op      (front_op)
    );

    // Decouple classification from execution
    dcfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_op    (front_op),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_op    (queue_op)
    );

    // Execute operations and hold the result until taken
    dcfb_back #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (queue_valid),
        .i_op       (queue_op),
        .o_pop      (queue_pop),
        .o_valid    (m_axis_tvalid),
        .o_result   (result),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = result;

endmodule

// ----- rtl/dcfb_front.sv -----
// Front end: frame assembly and item classification.
// Depends on dcfb_pkg; feeds dcfb_queue.
module dcfb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_command,
    input  logic [7:0]                    i_rx_byte,
    output dcfb_pkg::t_op                 o_op
);

    logic [dcfb_pkg::CNT_W-1:0] r_count, n_count;
    logic                       r_sig,   n_sig;
    logic [dcfb_pkg::ID_W-1:0]  r_id,    n_id;
    logic                       sig_bad;

    always_comb begin
        sig_bad = ((r_count == dcfb_pkg::POS_SIG_1) && (i_rx_byte != dcfb_pkg::SIG_1)) ||
                  ((r_count == dcfb_pkg::POS_SIG_2) && (i_rx_byte != dcfb_pkg::SIG_2)) ||
                  ((r_count == dcfb_pkg::POS_SIG_3) && (i_rx_byte != dcfb_pkg::SIG_3));
        n_count = r_count;
        n_sig   = r_sig;
        n_id    = r_id;
        o_op.kind = dcfb_pkg::OP_NONE;
        o_op.id   = r_id;
        if (i_command) begin
            o_op.kind = dcfb_pkg::OP_TICK;
        end else if (r_count == '0) begin
            if (i_rx_byte == dcfb_pkg::LEAD_BYTE) begin
                n_count = dcfb_pkg::CNT_W'(1);
                n_sig   = 1'b1;
                n_id    = '0;
            end
        end else begin
            if (sig_bad) begin
                n_sig = 1'b0;
            end
            if (r_count == dcfb_pkg::POS_ID_0) n_id[7:0]   = i_rx_byte;
            if (r_count == dcfb_pkg::POS_ID_1) n_id[15:8]  = i_rx_byte;
            if (r_count == dcfb_pkg::POS_ID_2) n_id[23:16] = i_rx_byte;
            if (r_count == dcfb_pkg::POS_ID_3) n_id[28:24] = i_rx_byte[4:0];
            if (r_count == dcfb_pkg::POS_LAST) begin
                n_count = '0;
                n_sig   = 1'b0;
                if (r_sig) begin
                    o_op.kind = dcfb_pkg::OP_FRAME;
                end
            end else begin
                n_count = r_count + dcfb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sig   <= 1'b0;
            r_id    <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_sig   <= n_sig;
            r_id    <= n_id;
        end
    end

endmodule

// ----- rtl/dcfb_queue.sv -----
// Two-entry queue of classified operations between front and back end.
// Depends on dcfb_pkg for the entry type.
module dcfb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcfb_pkg::t_op  i_op,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dcfb_pkg::t_op  o_op
);

    dcfb_pkg::t_op r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/dcfb_back.sv -----
// Back end: executes ticks and decoded frames on the button state and
// holds the result register. Depends on dcfb_pkg.
module dcfb_back #(
    parameter int unsigned BUTTON_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcfb_pkg::t_cfg     i_cfg,
    input  logic               i_op_valid,
    input  dcfb_pkg::t_op      i_op,
    output logic               o_pop,
    output logic               o_valid,
    output dcfb_pkg::t_result  o_result,
    input  logic               i_ready
);

    localparam int unsigned MB = dcfb_pkg::MAX_BUTTONS;

    logic [dcfb_pkg::STAMP_W-1:0] r_ms, n_ms;
    logic [dcfb_pkg::STAMP_W-1:0] r_stamp [MB];
    logic [7:0]                   r_buttons, n_buttons;
    logic                         r_valid;
    dcfb_pkg::t_result            r_result, n_result;

    logic [MB-1:0]                present;
    logic [MB-1:0]                expire;
    logic [dcfb_pkg::STAMP_W-1:0] elapsed [MB];
    logic [dcfb_pkg::ID_W:0]      prev_id;
    logic [dcfb_pkg::ID_W-1:0]    offset;
    logic                         id_ge_base;
    logic                         in_range;
    logic [2:0]                   btn;
    logic                         stamp_en;

    assign o_pop   = i_op_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_result = r_result;

    always_comb begin
        for (int b = 0; b < MB; b++) begin
            present[b] = (b < BUTTON_COUNT);
            elapsed[b] = (r_ms + dcfb_pkg::STAMP_W'(1)) - r_stamp[b];
            expire[b]  = present[b] && !i_cfg.toggle_mask[b] && r_buttons[b] &&
                         (elapsed[b] > {{(dcfb_pkg::STAMP_W - dcfb_pkg::HOLD_W){1'b0}},
                                        i_cfg.hold_ms});
        end
    end

    always_comb begin
        prev_id    = {1'b0, i_cfg.screen_next_id} + {{dcfb_pkg::ID_W{1'b0}}, 1'b1};
        id_ge_base = (i_op.id >= i_cfg.button_base_id);
        offset     = i_op.id - i_cfg.button_base_id;
        in_range   = id_ge_base && (offset[dcfb_pkg::ID_W-1:4] == '0) &&
                     ({1'b0, offset[3:0]} < 5'(2 * BUTTON_COUNT));
        btn        = offset[3:1];
    end

    always_comb begin
        n_ms      = r_ms;
        n_buttons = r_buttons;
        stamp_en  = 1'b0;
        n_result.frame_id    = '0;
        n_result.frame_done  = 1'b0;
        n_result.screen_step = 2'sd0;
        unique case (i_op.kind)
            dcfb_pkg::OP_TICK: begin
                n_ms      = r_ms + dcfb_pkg::STAMP_W'(1);
                n_buttons = r_buttons & ~expire;
            end
            dcfb_pkg::OP_FRAME: begin
                n_result.frame_id   = i_op.id;
                n_result.frame_done = 1'b1;
                priority if (i_op.id == i_cfg.screen_next_id) begin
                    n_result.screen_step = 2'sd1;
                end else if ({1'b0, i_op.id} == prev_id) begin
                    n_result.screen_step = -2'sd1;
                end else if (in_range) begin
                    if (offset[0]) begin
                        stamp_en = 1'b1;
                        if (i_cfg.toggle_mask[btn]) begin
                            n_buttons[btn] = ~r_buttons[btn];
                        end else begin
                            n_buttons[btn] = 1'b1;
                        end
                    end else begin
                        n_buttons[btn] = 1'b0;
                    end
                end else begin
                    // unknown ID: hold buttons, no screen step
                    n_result.screen_step = 2'sd0;
                end
            end
            default: begin
            end
        endcase
        n_result.switch_state = n_buttons;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MB; b++) begin
                r_stamp[b] <= '0;
            end
        end else if (o_pop && stamp_en) begin
            r_stamp[btn] <= r_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms      <= '0;
            r_buttons <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ms      <= n_ms;
                r_buttons <= n_buttons;
                r_valid   <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- bench/dash_can_frame_button_decoder_test.sv -----
// Self-checking testbench for dash_can_frame_button_decoder: frame, tick and
// button traffic with random stalls on both streams and several register settings.
// Depends on dcfb_pkg and the RTL of the block; needs nothing else.
module dash_can_frame_button_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BTN     = 8;
    localparam int LATENCY     = 4;        // extra wait in wait_drain after the last result
    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 250000;

    // command carried in tuser
    localparam bit CMD_BYTE = 1'b0;
    localparam bit CMD_TICK = 1'b1;

    // register indexes, byte address 4*i
    localparam int REG_HOLD_MS     = 0;
    localparam int REG_TOGGLE_MASK = 1;
    localparam int REG_BUTTON_BASE = 2;
    localparam int REG_SCREEN_NEXT = 3;
    localparam int NUM_REGS        = 4;

    localparam logic [31:0] ID_MASK = 32'h1FFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;    // [0] command (1 = millisecond tick)
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [7:0] switch_state, [9:8] screen_step,
                                         // [10] frame_done, [39:11] frame_id
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    dash_can_frame_button_decoder #(
        .BUTTON_COUNT(NUM_BTN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the block: register copies and decoder state, reset values
    // ------------------------------------------------------------------
    logic [15:0] cfg_hold_ms     = 16'd200;
    logic [7:0]  cfg_toggle_mask = 8'd12;
    logic [28:0] cfg_button_base = 29'h500;
    logic [28:0] cfg_screen_next = 29'h800;

    logic [31:0] ms_now = '0;
    logic [31:0] press_stamp [NUM_BTN];
    logic [7:0]  buttons = '0;
    int          frame_pos = 0;     // 0 = waiting for the lead byte
    bit          sig_ok = 1'b0;
    logic [31:0] id_acc = '0;

    initial begin
        for (int b = 0; b < NUM_BTN; b++) press_stamp[b] = '0;
    end

    dcfb_pkg::t_result button_results_q [$];  // decoder results still owed by the block
    int      items_sent = 0;
    int      mismatches = 0;
    int      cycle_count = 0;
    int      rx_wait = 0;
    bit      tx_idle = 1'b1;
    bit      rx_idle = 1'b1;
    int      tick_rate = 0;         // percent chance of a tick ahead of a frame byte

    // Advance the shadow decoder by one item and return what the block must emit.
    function automatic dcfb_pkg::t_result compute_button_result(input bit cmd,
                                                                input logic [7:0] rx);
        dcfb_pkg::t_result res;
        logic [31:0] id;
        logic [31:0] prev_id;
        logic [31:0] off;
        int          b;
        res = '0;
        if (cmd == CMD_TICK) begin
            ms_now = ms_now + 32'd1;
            // release momentary buttons held longer than hold_ms, modulo 2^32
            for (b = 0; b < NUM_BTN; b++) begin
                if (!cfg_toggle_mask[b] && buttons[b] &&
                    (ms_now - press_stamp[b]) > {16'b0, cfg_hold_ms})
                    buttons[b] = 1'b0;
            end
        end else if (frame_pos == 0) begin
            // stray bytes are dropped while waiting for the lead byte
            if (rx == dcfb_pkg::LEAD_BYTE) begin
                frame_pos = 1;
                sig_ok = 1'b1;
                id_acc = '0;
            end
        end else begin
            if ((frame_pos == dcfb_pkg::POS_SIG_1 && rx != dcfb_pkg::SIG_1) ||
                (frame_pos == dcfb_pkg::POS_SIG_2 && rx != dcfb_pkg::SIG_2) ||
                (frame_pos == dcfb_pkg::POS_SIG_3 && rx != dcfb_pkg::SIG_3))
                sig_ok = 1'b0;
            if (frame_pos >= dcfb_pkg::POS_ID_0 && frame_pos <= dcfb_pkg::POS_ID_3)
                id_acc = id_acc | ({24'b0, rx} << ((frame_pos - dcfb_pkg::POS_ID_0) * 8));
            if (frame_pos + 1 >= dcfb_pkg::FRAME_BYTES) begin
                frame_pos = 0;
                if (sig_ok) begin
                    id = id_acc & ID_MASK;
                    res.frame_done = 1'b1;
                    res.frame_id = id[28:0];
                    // previous-screen ID may reach bit 29 and then never matches
                    prev_id = {3'b0, cfg_screen_next} + 32'd1;
                    if (id == {3'b0, cfg_screen_next}) begin
                        res.screen_step = 2'sd1;
                    end else if (id == prev_id) begin
                        res.screen_step = -2'sd1;
                    end else if (id >= {3'b0, cfg_button_base}) begin
                        off = id - {3'b0, cfg_button_base};
                        if (off < 2 * NUM_BTN) begin
                            b = int'(off >> 1);
                            if (off[0]) begin
                                if (cfg_toggle_mask[b]) buttons[b] = ~buttons[b];
                                else buttons[b] = 1'b1;
                                press_stamp[b] = ms_now;
                            end else begin
                                buttons[b] = 1'b0;
                            end
                        end
                    end
                end
                sig_ok = 1'b0;
            end else begin
                frame_pos = frame_pos + 1;
            end
        end
        res.switch_state = buttons;
        return res;
    endfunction

    function automatic int draw_gap(input bit on);
        return on ? int'($urandom_range(0, 9)) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, compare each result with the oldest owed one
    // ------------------------------------------------------------------
    task automatic check_result(input dcfb_pkg::t_result got);
        dcfb_pkg::t_result want;
        if (button_results_q.size() == 0) begin
            $error("result with nothing pending: tdata %h", got);
            mismatches++;
        end else begin
            want = button_results_q.pop_front();
            if (got.switch_state !== want.switch_state) begin
                $error("switch_state: expected %h, got %h", want.switch_state, got.switch_state);
                mismatches++;
            end
            if (got.screen_step !== want.screen_step) begin
                $error("screen_step: expected %0d, got %0d", want.screen_step, got.screen_step);
                mismatches++;
            end
            if (got.frame_done !== want.frame_done) begin
                $error("frame_done: expected %b, got %b", want.frame_done, got.frame_done);
                mismatches++;
            end
            if (got.frame_id !== want.frame_id) begin
                $error("frame_id: expected %h, got %h", want.frame_id, got.frame_id);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(dcfb_pkg::t_result'(m_axis_tdata));
                rx_wait = draw_gap(rx_idle);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Send one item; tvalid stays high on return so back-to-back items need no gap.
    task automatic send_item(input bit cmd, input logic [7:0] rx);
        int gap;
        gap = draw_gap(tx_idle);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        button_results_q.push_back(compute_button_result(cmd, rx));
        items_sent++;
    endtask

    // Hold the input until every owed result is back and the pipeline is empty.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (button_results_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Write all four registers back to back; call only with the block idle.
    task automatic write_config(input logic [15:0] hold, input logic [7:0] tmask,
                                input logic [28:0] base, input logic [28:0] snext);
        logic [31:0] vals [NUM_REGS];
        vals[REG_HOLD_MS]     = {16'b0, hold};
        vals[REG_TOGGLE_MASK] = {24'b0, tmask};
        vals[REG_BUTTON_BASE] = {3'b0, base};
        vals[REG_SCREEN_NEXT] = {3'b0, snext};
        for (int r = 0; r < NUM_REGS; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 4'(4 * r);
            pwdata  <= vals[r];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_hold_ms     = hold;
        cfg_toggle_mask = tmask;
        cfg_button_base = base;
        cfg_screen_next = snext;
    endtask

    // Send the first len bytes of a frame; bad_pos 1..3 corrupts that signature byte.
    task automatic send_frame(input logic [31:0] raw_id, input int bad_pos, input int len);
        logic [7:0] fb [dcfb_pkg::FRAME_BYTES];
        fb[0] = dcfb_pkg::LEAD_BYTE;
        fb[1] = dcfb_pkg::SIG_1;
        fb[2] = dcfb_pkg::SIG_2;
        fb[3] = dcfb_pkg::SIG_3;
        for (int i = 0; i < 4; i++) fb[4 + i] = raw_id[8*i +: 8];
        // payload and checksum: random, with a lead byte now and then
        for (int i = 8; i < dcfb_pkg::FRAME_BYTES; i++)
            fb[i] = ($urandom_range(0, 7) == 0) ? dcfb_pkg::LEAD_BYTE : 8'($urandom);
        if (bad_pos >= 1 && bad_pos <= 3)
            fb[bad_pos] = fb[bad_pos] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < len; i++) begin
            if (tick_rate != 0 && $urandom_range(0, 99) < tick_rate)
                send_item(CMD_TICK, 8'($urandom));
            send_item(CMD_BYTE, fb[i]);
        end
    endtask

    // Pick an ID near the decoded ranges, with junk in the three masked bits at times.
    function automatic logic [31:0] pick_frame_id();
        logic [31:0] id;
        case ($urandom_range(0, 9))
            0:       id = {3'b0, cfg_screen_next};
            1:       id = {3'b0, cfg_screen_next} + 32'd1;
            7:       id = {3'b0, cfg_button_base} + (($urandom_range(0, 1) != 0) ? 32'd16
                                                                                 : -32'd1);
            8:       id = $urandom;
            default: id = {3'b0, cfg_button_base} + 32'($urandom_range(0, 15));
        endcase
        id = id & ID_MASK;
        if ($urandom_range(0, 3) == 0) id[31:29] = 3'($urandom);
        return id;
    endfunction

    // Mixed traffic: mostly good frames, plus ticks, broken frames and noise.
    task automatic run_traffic(input int n);
        int         start;
        logic [7:0] b;
        start = items_sent;
        while (items_sent - start < n) begin
            case ($urandom_range(0, 19))
                13, 14: repeat ($urandom_range(1, 25)) send_item(CMD_TICK, 8'($urandom));
                15, 16: send_frame(pick_frame_id(), $urandom_range(1, 3),
                                   dcfb_pkg::FRAME_BYTES);
                17: begin
                    repeat ($urandom_range(1, 4)) begin
                        b = 8'($urandom);
                        if (b == dcfb_pkg::LEAD_BYTE) b = b ^ 8'h01;
                        send_item(CMD_BYTE, b);
                    end
                end
                // cut a frame short: the next bytes complete it
                18: send_frame(pick_frame_id(), 0, $urandom_range(1, dcfb_pkg::FRAME_BYTES - 1));
                19: wait_drain();
                default: send_frame(pick_frame_id(), 0, dcfb_pkg::FRAME_BYTES);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: stray bytes, both screen steps, set/toggle/clear, bad signatures.
    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        tick_rate = 0;
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h43);
        send_item(CMD_TICK, 8'hFF);
        send_frame(32'h0000_0800, 0, dcfb_pkg::FRAME_BYTES);    // next screen
        send_frame(32'h0000_0801, 0, dcfb_pkg::FRAME_BYTES);    // previous screen
        send_frame(32'h0000_0501, 0, dcfb_pkg::FRAME_BYTES);    // button 0 on
        send_frame(32'h0000_0505, 0, dcfb_pkg::FRAME_BYTES);    // toggle button 2 on
        send_frame(32'h0000_0505, 0, dcfb_pkg::FRAME_BYTES);    // and off again
        send_frame(32'h0000_050F, 0, dcfb_pkg::FRAME_BYTES);    // button 7 on
        send_frame(32'h0000_050E, 0, dcfb_pkg::FRAME_BYTES);    // button 7 off
        for (int p = 1; p <= 3; p++) send_frame(32'h0000_0503, p, dcfb_pkg::FRAME_BYTES);
        send_frame(32'h4444_4444, 0, dcfb_pkg::FRAME_BYTES);    // lead bytes inside the frame
        send_frame(32'hFFFF_FFFF, 0, dcfb_pkg::FRAME_BYTES);
        send_frame(32'hE000_0503, 0, dcfb_pkg::FRAME_BYTES);    // top bits masked: button 1 on
        send_item(CMD_TICK, 8'h00);
    endtask

    // Register extremes, including a screen ID with no previous and a base at the top.
    task automatic test_config_extremes();
        logic [15:0] hold  [4] = '{16'd0, 16'hFFFF, 16'd1, 16'd5};
        logic [7:0]  tmask [4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        logic [28:0] base  [4] = '{29'h0, 29'h1FFF_FFFF, 29'h1FFF_FFF8, 29'h10};
        logic [28:0] snext [4] = '{29'h1FFF_FFFF, 29'h0, 29'h1FFF_FFFE, 29'h14};
        for (int ph = 0; ph < 4; ph++) begin
            wait_drain();
            write_config(hold[ph], tmask[ph], base[ph], snext[ph]);
            tx_idle = ph[0];
            rx_idle = ph[1];
            tick_rate = 10 * ph;
            run_traffic(60);
        end
    endtask

    // Random settings per phase until the item budget is spent.
    task automatic test_random();
        logic [31:0] base;
        logic [31:0] snext;
        logic [15:0] hold;
        while (items_sent < ITEM_TARGET) begin
            wait_drain();
            case ($urandom_range(0, 5))
                0:       hold = 16'd0;
                4:       hold = 16'($urandom);
                5:       hold = 16'hFFFF;
                default: hold = 16'($urandom_range(1, 20));
            endcase
            case ($urandom_range(0, 3))
                0:       base = $urandom & ID_MASK;
                1:       base = ID_MASK - 32'($urandom_range(0, 20));
                2:       base = 32'd0;
                default: base = 32'($urandom_range(0, 4096));
            endcase
            case ($urandom_range(0, 4))
                0:       snext = base + 32'($urandom_range(0, 17));   // overlaps buttons
                1:       snext = $urandom;
                2:       snext = ID_MASK;
                3:       snext = base - 32'($urandom_range(1, 3));
                default: snext = 32'($urandom_range(0, 4096));
            endcase
            write_config(hold, 8'($urandom), base[28:0], snext[28:0]);
            tx_idle = $urandom_range(0, 2) != 0;
            rx_idle = $urandom_range(0, 2) != 0;
            tick_rate = $urandom_range(0, 30);
            run_traffic($urandom_range(60, 140));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random();
        wait_drain();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
